// ----- src/cwsm_pkg.sv -----
// Shared types, widths and helpers for the clamped window smoother.
// Used by every module of the block except cwsm_ram; depends on nothing.
package cwsm_pkg;

    localparam int CNT_W       = 16;
    localparam int MAX_WINDOW  = 32;
    localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = CNT_W + $clog2(MAX_WINDOW);
    localparam int PSUM_W      = WIN_W + 1;
    localparam int TDATA_W     = ((CNT_W + 7) / 8) * 8;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int WS_W        = 6;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int STEP_W      = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    localparam logic [CFG_ADDR_W-1:0] REG_CEILING     = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = CFG_ADDR_W'(1);

    localparam logic [CNT_W-1:0] CEILING_RST   = '1;
    localparam logic [WIN_W-1:0] WINDOW_RST    = WIN_W'(1);

    typedef enum logic {
        CMD_AVG,
        CMD_FLUSH
    } cmd_kind_t;

    // len is the divisor for an average and the entry count for a flush
    typedef struct packed {
        cmd_kind_t          kind;
        logic [SUM_W-1:0]   sum;
        logic [WIN_W-1:0]   len;
        logic [IDX_W-1:0]   start;
    } cmd_t;

    typedef struct packed {
        logic flush_done;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD,
        BK_FL_ADDR,
        BK_FL_DATA
    } back_state_t;

    // slot arithmetic modulo MAX_WINDOW; b never exceeds MAX_WINDOW
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
        logic [PSUM_W-1:0] s;
        s = PSUM_W'(a) + PSUM_W'(b);
        if (s >= PSUM_W'(MAX_WINDOW))
        begin
            s = s - PSUM_W'(MAX_WINDOW);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ----- src/cwsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module cwsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- src/cwsm_front.sv -----
// Front end: config registers, clamp, delay-line writes, running sum.
// Issues average and flush commands into the queue. Uses cwsm_pkg.
module cwsm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cwsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cwsm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cwsm_pkg::CNT_W-1:0]       in_count,
    input  logic                             in_last,
    output logic                             wr_en,
    output logic [cwsm_pkg::IDX_W-1:0]       wr_addr,
    output logic [cwsm_pkg::CNT_W-1:0]       wr_data,
    output logic [cwsm_pkg::IDX_W-1:0]       rd_addr,
    input  logic [cwsm_pkg::CNT_W-1:0]       rd_data,
    output logic                             q_push,
    output cwsm_pkg::cmd_t                   q_cmd,
    input  logic                             q_ready,
    input  cwsm_pkg::back_status_t           status
);

    logic [cwsm_pkg::CNT_W-1:0] ceiling_reg, ceiling_next;
    logic [cwsm_pkg::WIN_W-1:0] win_reg, win_next;
    logic [cwsm_pkg::IDX_W-1:0] oldest_reg, oldest_next;
    logic [cwsm_pkg::WIN_W-1:0] fill_reg, fill_next;
    logic [cwsm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                       flush_pend_reg, flush_pend_next;
    logic                       fwd_hit_reg, fwd_hit_next;
    logic [cwsm_pkg::CNT_W-1:0] fwd_data_reg;

    logic                       accept;
    logic [cwsm_pkg::CNT_W-1:0] clamped;
    logic [cwsm_pkg::WIN_W-1:0] fill_after;
    logic [cwsm_pkg::SUM_W-1:0] sum_after;
    logic [cwsm_pkg::CNT_W-1:0] old_val;
    logic [cwsm_pkg::WS_W-1:0]  ws;
    logic [cwsm_pkg::WIN_W-1:0] eff_win;

    assign in_ready = !flush_pend_reg && q_ready;
    assign accept   = in_valid && in_ready;

    assign clamped    = (in_count > ceiling_reg) ? ceiling_reg : in_count;
    assign fill_after = fill_reg + cwsm_pkg::WIN_W'(1);
    assign sum_after  = sum_reg + cwsm_pkg::SUM_W'(clamped);

    // with nothing pending the oldest entry is the word arriving now
    assign old_val = (fill_reg == '0) ? clamped :
                     (fwd_hit_reg ? fwd_data_reg : rd_data);

    assign ws = cfg_wdata[cwsm_pkg::WS_W-1:0];

    always_comb
    begin
        if (ws == '0)
        begin
            eff_win = cwsm_pkg::WIN_W'(1);
        end
        else if (cwsm_pkg::PSUM_W'(ws) > cwsm_pkg::PSUM_W'(cwsm_pkg::MAX_WINDOW))
        begin
            eff_win = cwsm_pkg::WIN_W'(cwsm_pkg::MAX_WINDOW);
        end
        else
        begin
            eff_win = cwsm_pkg::WIN_W'(ws);
        end
    end

    always_comb
    begin
        ceiling_next    = ceiling_reg;
        win_next        = win_reg;
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        flush_pend_next = flush_pend_reg;
        q_push          = 1'b0;
        q_cmd           = '{kind: cwsm_pkg::CMD_AVG, sum: sum_after, len: win_reg,
                            start: oldest_reg};
        wr_en           = accept;
        wr_addr         = cwsm_pkg::idx_add(oldest_reg, fill_reg);
        wr_data         = clamped;

        if (status.flush_done)
        begin
            flush_pend_next = 1'b0;
        end

        if (accept)
        begin
            if (in_last)
            begin
                q_push          = 1'b1;
                q_cmd.kind      = cwsm_pkg::CMD_FLUSH;
                q_cmd.len       = fill_after;
                fill_next       = '0;
                sum_next        = '0;
                flush_pend_next = 1'b1;
            end
            else if (fill_after >= win_reg)
            begin
                q_push      = 1'b1;
                sum_next    = sum_after - cwsm_pkg::SUM_W'(old_val);
                fill_next   = fill_reg;
                oldest_next = cwsm_pkg::idx_add(oldest_reg, cwsm_pkg::WIN_W'(1));
            end
            else
            begin
                fill_next = fill_after;
                sum_next  = sum_after;
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_addr)
                cwsm_pkg::REG_CEILING:
                begin
                    ceiling_next = cfg_wdata[cwsm_pkg::CNT_W-1:0];
                end
                cwsm_pkg::REG_WINDOW_SIZE:
                begin
                    win_next  = eff_win;
                    fill_next = '0;
                    sum_next  = '0;
                end
                default:
                begin
                    ceiling_next = ceiling_reg;
                end
            endcase
        end
    end

    // prefetch the oldest entry for the next word; forward a same-cycle write
    assign rd_addr      = oldest_next;
    assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg    <= cwsm_pkg::CEILING_RST;
            win_reg        <= cwsm_pkg::WINDOW_RST;
            oldest_reg     <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            flush_pend_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            ceiling_reg    <= ceiling_next;
            win_reg        <= win_next;
            oldest_reg     <= oldest_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            flush_pend_reg <= flush_pend_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

endmodule

// ----- src/cwsm_cmd_fifo.sv -----
// Short command queue between front and back end.
// Holds cmd_t entries from cwsm_pkg.
module cwsm_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cwsm_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output cwsm_pkg::cmd_t  pop_cmd,
    output logic            pop_valid
);

    cwsm_pkg::cmd_t              entry_reg [cwsm_pkg::QDEPTH];
    logic [cwsm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cwsm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cwsm_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [cwsm_pkg::QPTR_W-1:0] ptr_inc(
        input logic [cwsm_pkg::QPTR_W-1:0] p);
        if (p == cwsm_pkg::QPTR_W'(cwsm_pkg::QDEPTH - 1))
        begin
            return '0;
        end
        return p + cwsm_pkg::QPTR_W'(1);
    endfunction

    assign push_ready = (cnt_reg != cwsm_pkg::QCNT_W'(cwsm_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (push && push_ready) ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = (pop && pop_valid) ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if ((push && push_ready) && !(pop && pop_valid))
        begin
            cnt_next = cnt_reg + cwsm_pkg::QCNT_W'(1);
        end
        else if (!(push && push_ready) && (pop && pop_valid))
        begin
            cnt_next = cnt_reg - cwsm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/cwsm_back.sv -----
// Back end: bit-serial divider for window averages and flush sequencer.
// Owns the output register. Uses cwsm_pkg.
module cwsm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cwsm_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic [cwsm_pkg::IDX_W-1:0]  rd_addr,
    input  logic [cwsm_pkg::CNT_W-1:0]  rd_data,
    output cwsm_pkg::back_status_t      status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cwsm_pkg::CNT_W-1:0]  out_value,
    output logic                        out_smoothed,
    output logic                        out_last
);

    cwsm_pkg::back_state_t state_reg, state_next;

    logic [cwsm_pkg::SUM_W-1:0]  num_reg, num_next;
    logic [cwsm_pkg::WIN_W-1:0]  den_reg, den_next;
    logic [cwsm_pkg::PSUM_W-1:0] rem_reg, rem_next;
    logic [cwsm_pkg::CNT_W-1:0]  quo_reg, quo_next;
    logic [cwsm_pkg::STEP_W-1:0] step_reg, step_next;
    logic [cwsm_pkg::IDX_W-1:0]  fl_idx_reg, fl_idx_next;
    logic [cwsm_pkg::WIN_W-1:0]  fl_cnt_reg, fl_cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [cwsm_pkg::CNT_W-1:0]  out_value_reg, out_value_next;
    logic                        out_smoothed_reg, out_smoothed_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic                        div_done;
    logic                        fl_final;
    logic [cwsm_pkg::PSUM_W-1:0] trial;
    logic                        qbit;

    assign out_free = !out_valid_reg || out_ready;
    assign div_done = (step_reg == cwsm_pkg::STEP_W'(cwsm_pkg::SUM_W - 1));
    assign fl_final = (fl_cnt_reg == cwsm_pkg::WIN_W'(1));
    assign trial    = {rem_reg[cwsm_pkg::PSUM_W-2:0], num_reg[cwsm_pkg::SUM_W-1]};
    assign qbit     = (trial >= cwsm_pkg::PSUM_W'(den_reg));
    assign rd_addr  = fl_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwsm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_cmd.kind == cwsm_pkg::CMD_AVG) ?
                                 cwsm_pkg::BK_DIV : cwsm_pkg::BK_FL_ADDR;
                end
            end
            cwsm_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = cwsm_pkg::BK_HOLD;
                end
            end
            cwsm_pkg::BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = cwsm_pkg::BK_IDLE;
                end
            end
            cwsm_pkg::BK_FL_ADDR:
            begin
                state_next = cwsm_pkg::BK_FL_DATA;
            end
            cwsm_pkg::BK_FL_DATA:
            begin
                if (out_free)
                begin
                    state_next = fl_final ? cwsm_pkg::BK_IDLE : cwsm_pkg::BK_FL_ADDR;
                end
            end
            default:
            begin
                state_next = cwsm_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop             = 1'b0;
        status.flush_done = 1'b0;
        num_next          = num_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        fl_idx_next       = fl_idx_reg;
        fl_cnt_next       = fl_cnt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_value_next    = out_value_reg;
        out_smoothed_next = out_smoothed_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            cwsm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    num_next    = q_cmd.sum;
                    den_next    = q_cmd.len;
                    rem_next    = '0;
                    step_next   = '0;
                    fl_idx_next = q_cmd.start;
                    fl_cnt_next = q_cmd.len;
                end
            end
            cwsm_pkg::BK_DIV:
            begin
                // one restoring step per cycle, numerator MSB first
                rem_next  = qbit ? (trial - cwsm_pkg::PSUM_W'(den_reg)) : trial;
                quo_next  = {quo_reg[cwsm_pkg::CNT_W-2:0], qbit};
                num_next  = {num_reg[cwsm_pkg::SUM_W-2:0], 1'b0};
                step_next = step_reg + cwsm_pkg::STEP_W'(1);
            end
            cwsm_pkg::BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_value_next    = quo_reg;
                    out_smoothed_next = 1'b1;
                    out_last_next     = 1'b0;
                end
            end
            cwsm_pkg::BK_FL_ADDR:
            begin
                fl_idx_next = fl_idx_reg;
            end
            cwsm_pkg::BK_FL_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_value_next    = rd_data;
                    out_smoothed_next = 1'b0;
                    out_last_next     = fl_final;
                    fl_idx_next       = cwsm_pkg::idx_add(fl_idx_reg, cwsm_pkg::WIN_W'(1));
                    fl_cnt_next       = fl_cnt_reg - cwsm_pkg::WIN_W'(1);
                    status.flush_done = fl_final;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwsm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            fl_cnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            fl_cnt_reg    <= fl_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg          <= num_next;
        den_reg          <= den_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        fl_idx_reg       <= fl_idx_next;
        out_value_reg    <= out_value_next;
        out_smoothed_reg <= out_smoothed_next;
        out_last_reg     <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_smoothed = out_smoothed_reg;
    assign out_last     = out_last_reg;

endmodule

// ----- src/count_clamp_window_smoother_unit.sv -----
// Clamped forward moving average over a stream of read counts: each count
// is clamped to the configured ceiling and position i is replaced by the truncated mean
// of the clamped counts i..i+W-1; the final W positions of a stream come out
// clamped but unaveraged once the word marked tlast arrives. The front end
// takes one input word per cycle while its two-entry command queue has room.
// Each smoothed result comes from the back end's one-bit-per-cycle divider,
// which starts a new command only after the last result is loaded for
// output, so a steady stream is paced by the divider. A flush emits one
// word per delay-line RAM read, and the input stays stalled from the tlast
// word until the last flushed word has been loaded for output.
// No clearing pass after reset; configuration takes effect at once.
// Depends on cwsm_pkg, cwsm_ram, cwsm_front, cwsm_cmd_fifo and cwsm_back.
module count_clamp_window_smoother_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cwsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cwsm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cwsm_pkg::TDATA_W-1:0]      s_axis_tdata,   // [15:0] count
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cwsm_pkg::TDATA_W-1:0]      m_axis_tdata,   // [15:0] value
    output logic                              m_axis_tuser,   // [0] smoothed
    output logic                              m_axis_tlast
);

    logic                        wr_en;
    logic [cwsm_pkg::IDX_W-1:0]  wr_addr;
    logic [cwsm_pkg::CNT_W-1:0]  wr_data;
    logic [cwsm_pkg::IDX_W-1:0]  front_raddr;
    logic [cwsm_pkg::CNT_W-1:0]  front_rdata;
    logic [cwsm_pkg::IDX_W-1:0]  back_raddr;
    logic [cwsm_pkg::CNT_W-1:0]  back_rdata;
    logic                        q_push;
    logic                        q_ready;
    cwsm_pkg::cmd_t              q_in;
    cwsm_pkg::cmd_t              q_out;
    logic                        q_valid;
    logic                        q_pop;
    cwsm_pkg::back_status_t      status;
    logic [cwsm_pkg::CNT_W-1:0]  out_value;

    // two copies of the delay line: one for the sum update, one for flushing
    cwsm_ram #(.WIDTH(cwsm_pkg::CNT_W), .DEPTH(cwsm_pkg::MAX_WINDOW)) u_ram_front (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    cwsm_ram #(.WIDTH(cwsm_pkg::CNT_W), .DEPTH(cwsm_pkg::MAX_WINDOW)) u_ram_back (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    cwsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_count  (s_axis_tdata[cwsm_pkg::CNT_W-1:0]),
        .in_last   (s_axis_tlast),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (front_raddr),
        .rd_data   (front_rdata),
        .q_push    (q_push),
        .q_cmd     (q_in),
        .q_ready   (q_ready),
        .status    (status)
    );

    cwsm_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_cmd    (q_out),
        .pop_valid  (q_valid)
    );

    cwsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_out),
        .q_pop        (q_pop),
        .rd_addr      (back_raddr),
        .rd_data      (back_rdata),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_value    (out_value),
        .out_smoothed (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = cwsm_pkg::TDATA_W'(out_value);

endmodule

// ----- src/cwsm_checker.sv -----
// Port-level checks for count_clamp_window_smoother_unit, bound to the top.
// Depends on cwsm_pkg for port widths.
module cwsm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [cwsm_pkg::TDATA_W-1:0]      m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // averages never close a stream
    a_avg_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("smoothed word marked last");

    // input stalls while the tail of a stream is flushed
    a_stall_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted during flush");

    // handshakes are always known, and so is a valid result word
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}) &&
        (!m_axis_tvalid || !$isunknown({m_axis_tdata, m_axis_tuser, m_axis_tlast})))
        else $error("unknown value on result port");

endmodule

bind count_clamp_window_smoother_unit cwsm_checker u_cwsm_checker (.*);
